// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache: status codes, ARP field values
// and the per-request decision record passed from the match logic.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [15:0] HW_ETHERNET   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4    = 16'h0800;
    localparam logic [31:0] IP_BROADCAST  = 32'hFFFF_FFFF;
    localparam logic [31:0] IP_EMPTY      = 32'h0000_0000;
    localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] MAC_NONE      = 48'h0000_0000_0000;

    localparam logic KIND_LEARN  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_KNOWN   = 3'd1,
        ST_ADDED   = 3'd2,
        ST_FULL    = 3'd3,
        ST_HIT     = 3'd4,
        ST_MISS    = 3'd5
    } arpc_status_t;

    typedef struct packed {
        arpc_status_t status;
        logic         send_reply;
        logic         write;      // store ip/mac into the chosen slot
        logic         read;       // fetch the mac of the chosen slot
        logic         hit_slot0;  // lookup hit on the broadcast slot
    } arpc_dec_t;

endpackage

// ===== rtl/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with a registered read port that
// holds its data while read enable is low.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/arpc_match.sv =====
// ----------------------------------------------------------------------------
// arpc_match
// Compares a request against every stored IP, finds the lowest matching and
// the lowest empty slot, and decides status, reply, write and read.
// ----------------------------------------------------------------------------
module arpc_match
    import arpc_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic [31:0]                entry_ip [ENTRIES],
    input  logic                       kind,
    input  logic [15:0]                op_code,
    input  logic [15:0]                hw_type,
    input  logic [15:0]                proto_type,
    input  logic [31:0]                ip_addr,
    output arpc_dec_t                  dec,
    output logic [$clog2(ENTRIES)-1:0] slot_idx
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] empty;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   empty_idx;
    logic               learnable;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (entry_ip[i] == ip_addr);
            empty[i] = (entry_ip[i] == IP_EMPTY);
        end
    end

    // lowest set bit wins
    always_comb begin
        match_idx = '0;
        empty_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                match_idx = IDX_W'(i);
            end
            if (empty[i]) begin
                empty_idx = IDX_W'(i);
            end
        end
    end

    assign learnable = (op_code == OP_REQUEST) && (hw_type == HW_ETHERNET)
                    && (proto_type == PROTO_IPV4);

    always_comb begin
        dec            = '0;
        dec.status     = ST_IGNORED;
        slot_idx       = match_idx;
        if (kind == KIND_LOOKUP) begin
            // ip zero would match empty slots, so it never hits
            if ((ip_addr != IP_EMPTY) && (|match)) begin
                dec.status    = ST_HIT;
                dec.read      = 1'b1;
                dec.hit_slot0 = (match_idx == '0);
            end else begin
                dec.status = ST_MISS;
            end
        end else if (!learnable) begin
            dec.status = ST_IGNORED;
        end else if (|match) begin
            dec.status     = ST_KNOWN;
            dec.send_reply = 1'b1;
        end else if (|empty) begin
            dec.status     = ST_ADDED;
            dec.send_reply = 1'b1;
            dec.write      = 1'b1;
            slot_idx       = empty_idx;
        end else begin
            dec.status = ST_FULL;
        end
    end

endmodule

// ===== rtl/arp_cache_learn_lookup_core.sv =====
// ----------------------------------------------------------------------------
// arp_cache_learn_lookup_core
// IPv4-to-MAC cache with learn and lookup requests on one stream.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser selects the request (0 learn, 1 lookup); tdata
// carries the ARP opcode, hardware type, protocol type, IP and MAC. Every
// request gives exactly one result on m_*: status, reply flag and the MAC
// found on a lookup hit.
// The request sits in the input register, then the table compare and
// priority select feed the result register, which drives m_tvalid; the step
// between the two waits while a result that was not taken is held.
// Throughput is one request per cycle while m_tready is high; it is set by
// the parallel compare over the IP registers and the one read port of the
// MAC RAM. A learn takes effect for the request directly behind it.
// Reset restores the table at once: slot 0 holds the broadcast entry, all
// other IP registers are zero (empty). The MAC RAM is not cleared; a slot is
// only read after it was written, and the broadcast MAC is a constant.
// When m_tready is low the result holds and one more request is taken into
// the input register; s_tready then drops until the result moves on.
// ----------------------------------------------------------------------------
module arp_cache_learn_lookup_core
    import arpc_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op_code[15:0], hw_type[31:16], proto_type[47:32], ip_addr[79:48],
    // mac_addr[127:80]
    input  logic [127:0] s_tdata,
    // kind[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], send_reply[3], found_mac[51:4], zero[55:52]
    output logic [55:0]  m_tdata
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic               kind_reg;
    logic [15:0]        op_code_reg;
    logic [15:0]        hw_type_reg;
    logic [15:0]        proto_type_reg;
    logic [31:0]        ip_addr_reg;
    logic [47:0]        mac_addr_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    arpc_status_t       status_reg;
    logic               reply_reg;
    logic               hit0_reg;

    logic [31:0]        entry_ip_reg [ENTRIES];
    arpc_dec_t          dec;
    logic [IDX_W-1:0]   slot_idx;
    logic               advance;
    logic [47:0]        ram_rdata;
    logic [47:0]        found_mac;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg       <= s_tuser;
            op_code_reg    <= s_tdata[15:0];
            hw_type_reg    <= s_tdata[31:16];
            proto_type_reg <= s_tdata[47:32];
            ip_addr_reg    <= s_tdata[79:48];
            mac_addr_reg   <= s_tdata[127:80];
        end
    end

    // ip table, slot 0 starts as the broadcast entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                entry_ip_reg[i] <= (i == 0) ? IP_BROADCAST : IP_EMPTY;
            end
        end else if (advance && dec.write) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_idx == IDX_W'(i)) begin
                    entry_ip_reg[i] <= ip_addr_reg;
                end
            end
        end
    end

    arpc_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .entry_ip   (entry_ip_reg),
        .kind       (kind_reg),
        .op_code    (op_code_reg),
        .hw_type    (hw_type_reg),
        .proto_type (proto_type_reg),
        .ip_addr    (ip_addr_reg),
        .dec        (dec),
        .slot_idx   (slot_idx)
    );

    arpc_ram #(
        .WIDTH (48),
        .DEPTH (ENTRIES)
    ) u_mac_ram (
        .aclk  (aclk),
        .we    (advance && dec.write),
        .waddr (slot_idx),
        .wdata (mac_addr_reg),
        .re    (advance && dec.read),
        .raddr (slot_idx),
        .rdata (ram_rdata)
    );

    // result register, the mac itself sits in the ram read register
    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= dec.status;
            reply_reg  <= dec.send_reply;
            hit0_reg   <= dec.hit_slot0;
        end
    end

    always_comb begin
        found_mac = MAC_NONE;
        if (status_reg == ST_HIT) begin
            found_mac = hit0_reg ? MAC_BROADCAST : ram_rdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, found_mac, reply_reg, status_reg};

`ifndef SYNTHESIS
    a_slot0_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_ip_reg[0] == IP_BROADCAST)
        else $error("broadcast slot was overwritten");

    a_write_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && dec.write |-> entry_ip_reg[slot_idx] == IP_EMPTY)
        else $error("learn wrote into an occupied slot");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dec.write && dec.read))
        else $error("request both writes and reads the mac ram");

    a_reply_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && reply_reg |-> status_reg == ST_KNOWN || status_reg == ST_ADDED)
        else $error("reply flagged for a status that needs none");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ARP cache core. Learn and lookup requests are
// driven on the s_* stream with random gaps while m_tready stalls at random.
// A local copy of the IP/MAC table predicts each result at acceptance, and
// results are checked in order against the queue of pending predictions.
// ----------------------------------------------------------------------------
module tb;
    import arpc_pkg::*;

    localparam int ENTRIES = 32;

    typedef struct packed {
        arpc_status_t status;
        logic         send_reply;
        logic [47:0]  found_mac;
    } arp_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;

    // local copy of the cache contents
    logic [31:0]  cache_ip [ENTRIES];
    logic [47:0]  cache_mac [ENTRIES];
    arp_result_t  pending_results [$];

    int           errors = 0;
    bit           src_idle = 1'b0;
    bit           sink_stall = 1'b0;
    int           ready_hold = 0;

    arp_cache_learn_lookup_core #(
        .ENTRIES (ENTRIES)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int source_gap();
        if (!src_idle || $urandom_range(0, 99) < 60) begin
            return 0;
        end
        return gap_length();
    endfunction

    // one result per request, table updated as the hardware would
    function automatic arp_result_t predict_arp_result(input logic kind,
            input logic [15:0] op, input logic [15:0] hw, input logic [15:0] proto,
            input logic [31:0] ip, input logic [47:0] mac);
        arp_result_t res;
        int          slot;
        res = '{status: ST_MISS, send_reply: 1'b0, found_mac: MAC_NONE};
        slot = -1;
        if (kind == KIND_LOOKUP) begin
            if (ip != IP_EMPTY) begin
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (cache_ip[i] == ip) slot = i;
                end
            end
            if (slot >= 0) begin
                res.status = ST_HIT;
                res.found_mac = cache_mac[slot];
            end
        end else if (op != OP_REQUEST || hw != HW_ETHERNET || proto != PROTO_IPV4) begin
            res.status = ST_IGNORED;
        end else begin
            // ip zero matches any empty slot, so it is acknowledged unless full
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (cache_ip[i] == ip) slot = i;
            end
            if (slot >= 0) begin
                res.status = ST_KNOWN;
                res.send_reply = 1'b1;
            end else begin
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (cache_ip[i] == IP_EMPTY) slot = i;
                end
                if (slot >= 0) begin
                    cache_ip[slot] = ip;
                    cache_mac[slot] = mac;
                    res.status = ST_ADDED;
                    res.send_reply = 1'b1;
                end else begin
                    res.status = ST_FULL;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] stored_ip();
        logic [31:0] cand [$];
        for (int i = 0; i < ENTRIES; i++) begin
            if (cache_ip[i] != IP_EMPTY) cand.push_back(cache_ip[i]);
        end
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_ip(input int new_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < new_pct) begin
            return $urandom;
        end else if (r < new_pct + 3) begin
            return IP_EMPTY;
        end
        return stored_ip();
    endfunction

    // called at a rising edge; leaves tvalid high after the handshake
    task automatic send_request(input logic kind, input logic [15:0] op,
            input logic [15:0] hw, input logic [15:0] proto,
            input logic [31:0] ip, input logic [47:0] mac);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {mac, ip, proto, hw, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_arp_result(kind, op, hw, proto, ip, mac));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic random_request(input int new_pct);
        logic        kind;
        logic [15:0] op;
        logic [15:0] hw;
        logic [15:0] proto;
        logic [47:0] mac;
        kind = 1'($urandom_range(0, 1));
        op = OP_REQUEST;
        hw = HW_ETHERNET;
        proto = PROTO_IPV4;
        mac = 48'({$urandom, $urandom});
        if (kind == KIND_LOOKUP) begin
            op = 16'($urandom);
            hw = 16'($urandom);
            proto = 16'($urandom);
        end else if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: op = 16'($urandom);
                1: hw = 16'($urandom);
                default: proto = 16'($urandom);
            endcase
        end
        send_request(kind, op, hw, proto, pick_ip(kind == KIND_LOOKUP ? 30 : new_pct), mac);
    endtask

    task automatic test_directed();
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, IP_BROADCAST, 48'h0);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, IP_EMPTY, 48'h0);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, 32'h0000_0001, 48'h0);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, IP_EMPTY,
                     48'h1234_5678_9ABC);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, IP_BROADCAST,
                     MAC_NONE);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 32'hC0A8_0001,
                     MAC_BROADCAST);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 32'h0000_0001,
                     MAC_NONE);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 32'hFFFF_FFFE,
                     48'h8000_0000_0000);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 32'h8000_0000,
                     48'h0000_0000_0001);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 32'hC0A8_0001,
                     48'h0A0B_0C0D_0E0F);
        // malformed packets, one field off at a time
        send_request(KIND_LEARN, 16'h0002, HW_ETHERNET, PROTO_IPV4, 32'h0A00_0001,
                     48'h1);
        send_request(KIND_LEARN, 16'hFFFF, HW_ETHERNET, PROTO_IPV4, 32'h0A00_0001,
                     48'h2);
        send_request(KIND_LEARN, 16'h0000, HW_ETHERNET, PROTO_IPV4, 32'h0A00_0001,
                     48'h3);
        send_request(KIND_LEARN, OP_REQUEST, 16'hFFFF, PROTO_IPV4, 32'h0A00_0001, 48'h4);
        send_request(KIND_LEARN, OP_REQUEST, 16'h0000, PROTO_IPV4, 32'h0A00_0001, 48'h5);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, 16'hFFFF, 32'h0A00_0001, 48'h6);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, 16'h0806, 32'h0A00_0001, 48'h7);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, 32'hC0A8_0001, 48'h0);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, 32'h0000_0001, 48'h0);
        send_request(KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFE,
                     MAC_BROADCAST);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, 32'h8000_0000, 48'h0);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, 32'h0A00_0001, 48'h0);
        // learn straight followed by its lookup
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 32'h0A0A_0A0A,
                     48'h5555_AAAA_5555);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, 32'h0A0A_0A0A, 48'h0);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, IP_BROADCAST, 48'h0);
    endtask

    task automatic test_random(input int count, input int new_pct);
        for (int n = 0; n < count; n++) begin
            // stretches with and without idling on either side
            if (n % 100 == 0) begin
                src_idle = ($urandom_range(0, 2) != 0);
                sink_stall = ($urandom_range(0, 2) != 0);
            end
            random_request(new_pct);
        end
    endtask

    task automatic test_sender_pause();
        src_idle = 1'b1;
        sink_stall = 1'b1;
        repeat (10) random_request(5);
        wait_drained();
        repeat (10) random_request(5);
    endtask

    task automatic test_fill_table();
        bit free;
        free = 1'b1;
        while (free) begin
            send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4,
                         $urandom_range(1, 32'hFFFF_FFFF), 48'({$urandom, $urandom}));
            free = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (cache_ip[i] == IP_EMPTY) free = 1'b1;
            end
        end
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 32'h7F00_0001,
                     48'h1);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, IP_EMPTY, 48'h2);
        send_request(KIND_LEARN, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, cache_ip[ENTRIES - 1],
                     48'h3);
        send_request(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, IP_EMPTY, 48'h0);
        for (int i = 0; i < ENTRIES; i++) begin
            send_request(KIND_LOOKUP, 16'($urandom), 16'($urandom), 16'($urandom),
                         cache_ip[i], 48'h0);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        arp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] != want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[3] != want.send_reply) begin
                    $display("%0t: send_reply expected %0b actual %0b", $time,
                             want.send_reply, m_tdata[3]);
                    errors++;
                end
                if (m_tdata[51:4] != want.found_mac) begin
                    $display("%0t: found_mac expected %h actual %h", $time, want.found_mac,
                             m_tdata[51:4]);
                    errors++;
                end
            end
        end
    end

    // result back-pressure, mostly short stalls and now and then a long one
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (!sink_stall) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            ready_hold = gap_length();
        end else begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 4);
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            cache_ip[i] = IP_EMPTY;
            cache_mac[i] = MAC_NONE;
        end
        cache_ip[0] = IP_BROADCAST;
        cache_mac[0] = MAC_BROADCAST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(600, 4);
        test_sender_pause();
        test_fill_table();
        test_random(800, 20);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== arp_cache_learn_lookup_core.f =====
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_match.sv
rtl/arp_cache_learn_lookup_core.sv
test/tb.sv
